// ===== hdl/ble_pkg.sv =====
// Shared types, constants and the configuration register map of the breath leak estimator.
package ble_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CFG_ADDR_W = 4;

  localparam logic [2:0] MODE_OPEN   = 3'd0;
  localparam logic [2:0] MODE_HELD   = 3'd1;
  localparam logic [2:0] MODE_FINRST = 3'd2;
  localparam logic [2:0] MODE_RST    = 3'd3;
  localparam logic [2:0] MODE_FIN    = 3'd4;
  localparam logic [2:0] MODE_IDLE   = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] ADDR_COEF_FLOOR = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_COEF_CEIL  = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LEAK_CEIL  = 4'h8;
  localparam logic [CFG_ADDR_W-1:0] ADDR_ROOT_FLOOR = 4'hC;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] pressure;
    logic signed [15:0] flow;
    logic               readings_finite;
  } in_word_t;

  typedef struct packed {
    logic [14:0]        leak_flow;
    logic [15:0]        coefficient;
    logic               coefficient_valid;
    logic signed [23:0] balance_coefficient;
    logic               breath_finished;
    logic [14:0]        mean_leak;
    logic               mean_leak_valid;
  } out_word_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic               do_finish;
    logic               clr_coef;
    logic               clr_breath;
    logic               do_open;
    logic               ok;
    logic signed [15:0] flow;
    logic [7:0]         root;
  } cmd_t;

  typedef struct packed {
    logic [15:0] coef_floor;
    logic [15:0] coef_ceil;
    logic [14:0] leak_ceil;
    logic [27:0] root_floor;
  } cfg_t;

endpackage

// ===== hdl/ble_front.sv =====
// Front end: classifies an input word and takes the square root of its pressure bit-serially.
module ble_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ble_pkg::in_word_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output ble_pkg::cmd_t    cmd_data
);
  import ble_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_SEND} state_t;

  state_t      state_r;
  logic [15:0] rem_r;
  logic [15:0] res_r;
  logic [15:0] bit_r;
  cmd_t        cmd_r;
  logic [16:0] trial;
  logic [15:0] res_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign cmd_valid = (state_r == S_SEND);
  assign cmd_data  = cmd_r;

  // One digit of the restoring square root each cycle.
  assign trial   = {1'b0, rem_r} - ({1'b0, res_r} + {1'b0, bit_r});
  assign res_nxt = trial[16] ? (res_r >> 1) : (res_r >> 1) + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r.do_finish  <= (in_data.mode == MODE_FINRST) || (in_data.mode == MODE_FIN);
            cmd_r.clr_coef   <= (in_data.mode == MODE_RST) || (in_data.mode == MODE_IDLE);
            cmd_r.clr_breath <= (in_data.mode == MODE_FINRST) || (in_data.mode == MODE_RST) ||
                                (in_data.mode == MODE_IDLE);
            cmd_r.do_open    <= (in_data.mode == MODE_OPEN) || (in_data.mode == MODE_FINRST) ||
                                (in_data.mode == MODE_RST);
            cmd_r.ok         <= in_data.readings_finite && !in_data.pressure[15] &&
                                (in_data.pressure != 16'sd0);
            cmd_r.flow       <= in_data.flow;
            rem_r            <= in_data.pressure[15] ? 16'd0 : in_data.pressure;
            res_r            <= 16'd0;
            bit_r            <= 16'h4000;
            state_r          <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (!trial[16]) begin
            rem_r <= trial[15:0];
          end
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          if (bit_r == 16'd1) begin
            cmd_r.root <= res_nxt[7:0];
            state_r    <= S_SEND;
          end
        end
        S_SEND: begin
          if (!cmd_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Flags the first send cycle, in which the root has just been loaded.
  logic root_ld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) root_ld_r <= 1'b0;
    else        root_ld_r <= (state_r == S_ROOT) && (bit_r == 16'd1);
  end

  a_root_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && bit_r == 16'd1) |=> (state_r == S_SEND))
    else $error("root did not finish into send");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> in_stall)
    else $error("input taken while root busy");
  a_ld_once: assert property (@(posedge clk) disable iff (!rst_n)
    root_ld_r |-> (state_r == S_SEND))
    else $error("root load outside send");

endmodule

// ===== hdl/ble_queue.sv =====
// Two-entry command queue between the front and back ends.
module ble_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  ble_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_stall,
  output ble_pkg::cmd_t rd_data
);
  import ble_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wp_r == rp_r))
    else $error("queue pointers inconsistent");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |=> (cnt_r != 2'd0) || $past(pop))
    else $error("queue drained without pop");

endmodule

// ===== hdl/ble_back.sv =====
// Back end: breath sums, coefficient division, leak flow and mean leak, one step at a time.
module ble_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ble_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  ble_pkg::cmd_t     cmd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ble_pkg::out_word_t out_data
);
  import ble_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_KDIV, S_MDIV, S_APPLY, S_LEAK, S_OUT
  } state_t;

  localparam logic [COUNT_BITS-1:0] SMAX = '1;

  state_t                  state_r, state_nxt;
  cmd_t                    c_r, c_nxt;
  logic signed [31:0]      flow_total_r, flow_total_nxt;
  logic [27:0]             root_total_r, root_total_nxt;
  logic                    breath_invalid_r, breath_invalid_nxt;
  logic [15:0]             coef_r, coef_nxt;
  logic                    coef_valid_r, coef_valid_nxt;
  logic signed [23:0]      balance_r, balance_nxt;
  logic [31:0]             leak_total_r, leak_total_nxt;
  logic [COUNT_BITS-1:0]   leak_samples_r, leak_samples_nxt;
  logic                    leak_mean_invalid_r, leak_mean_invalid_nxt;
  logic                    fin_r, fin_nxt;
  logic [14:0]             mean_r, mean_nxt;
  logic                    mean_ok_r, mean_ok_nxt;
  logic                    k_ok_r, k_ok_nxt;
  logic                    kneg_r, kneg_nxt;
  // Shared restoring divider: 38-bit dividend, up to 32-bit divisor.
  logic [37:0]             quo_r, quo_nxt;
  logic [31:0]             rem_r, rem_nxt;
  logic [31:0]             dvs_r, dvs_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic [14:0]             leak_r;
  logic [23:0]             prod_r;
  out_word_t               out_r, out_nxt;
  logic                    out_v_r, out_v_nxt;

  logic [32:0] rsh;
  logic [33:0] rsub;
  logic [37:0] qfin;
  assign rsh  = {rem_r, quo_r[37]};
  assign rsub = {1'b0, rsh} - {2'b0, dvs_r};
  // Quotient including the bit decided in this cycle.
  assign qfin = {quo_r[36:0], ~rsub[33]};

  logic [37:0] fmag;
  assign fmag = flow_total_r[31] ? 38'(-{{6{flow_total_r[31]}}, flow_total_r}) << 6
                                 : 38'({6'd0, flow_total_r}) << 6;

  assign cmd_stall = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  logic signed [38:0] kval;
  assign kval = kneg_r ? -$signed({1'b0, qfin}) : $signed({1'b0, qfin});

  logic signed [32:0] fsum;
  logic [28:0]        rsum;
  logic [32:0]        lsum;
  assign fsum = 33'(flow_total_r) + 33'(c_r.flow);
  assign rsum = {1'b0, root_total_r} + 29'(c_r.root);
  assign lsum = {1'b0, leak_total_r} + 33'(leak_r);

  always_comb begin
    state_nxt             = state_r;
    c_nxt                 = c_r;
    flow_total_nxt        = flow_total_r;
    root_total_nxt        = root_total_r;
    breath_invalid_nxt    = breath_invalid_r;
    coef_nxt              = coef_r;
    coef_valid_nxt        = coef_valid_r;
    balance_nxt           = balance_r;
    leak_total_nxt        = leak_total_r;
    leak_samples_nxt      = leak_samples_r;
    leak_mean_invalid_nxt = leak_mean_invalid_r;
    fin_nxt               = fin_r;
    mean_nxt              = mean_r;
    mean_ok_nxt           = mean_ok_r;
    k_ok_nxt              = k_ok_r;
    kneg_nxt              = kneg_r;
    quo_nxt               = quo_r;
    rem_nxt               = rem_r;
    dvs_nxt               = dvs_r;
    cnt_nxt               = cnt_r;
    out_nxt               = out_r;
    out_v_nxt             = out_v_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          c_nxt       = cmd_data;
          fin_nxt     = cmd_data.do_finish;
          mean_nxt    = '0;
          mean_ok_nxt = 1'b0;
          k_ok_nxt    = !breath_invalid_r && (root_total_r != 28'd0) &&
                        (root_total_r >= cfg.root_floor);
          kneg_nxt    = flow_total_r[31];
          quo_nxt     = fmag;
          rem_nxt     = '0;
          dvs_nxt     = {4'd0, root_total_r};
          cnt_nxt     = 6'd38;
          state_nxt   = cmd_data.do_finish ? S_KDIV : S_APPLY;
        end
      end
      S_KDIV, S_MDIV: begin
        rem_nxt = rsub[33] ? rsh[31:0] : rsub[31:0];
        quo_nxt = qfin;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          if (state_r == S_KDIV) begin
            coef_nxt       = '0;
            coef_valid_nxt = 1'b0;
            balance_nxt    = '0;
            if (k_ok_r) begin
              if (kval > 39'sd8388607)       balance_nxt = 24'sh7FFFFF;
              else if (kval < -39'sd8388608) balance_nxt = 24'sh800000;
              else                           balance_nxt = kval[23:0];
              if (kval < $signed({23'd0, cfg.coef_floor}))     coef_nxt = cfg.coef_floor;
              else if (kval > $signed({23'd0, cfg.coef_ceil})) coef_nxt = cfg.coef_ceil;
              else                                             coef_nxt = kval[15:0];
              coef_valid_nxt = 1'b1;
            end
            // Finishing the coefficient division also loads the mean division.
            quo_nxt   = {6'd0, leak_total_r};
            rem_nxt   = '0;
            dvs_nxt   = 32'(leak_samples_r);
            cnt_nxt   = 6'd38;
            state_nxt = S_MDIV;
          end else begin
            if (!leak_mean_invalid_r && !breath_invalid_r && leak_samples_r != '0) begin
              mean_nxt    = qfin[14:0];
              mean_ok_nxt = 1'b1;
            end
            state_nxt = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        if (c_r.clr_coef) begin
          coef_nxt       = '0;
          coef_valid_nxt = 1'b0;
          balance_nxt    = '0;
        end
        if (c_r.clr_breath) begin
          flow_total_nxt        = '0;
          root_total_nxt        = '0;
          breath_invalid_nxt    = 1'b0;
          leak_total_nxt        = '0;
          leak_samples_nxt      = '0;
          leak_mean_invalid_nxt = 1'b0;
        end
        if (c_r.do_open) begin
          if (!c_r.ok) begin
            breath_invalid_nxt = 1'b1;
          end else if (c_r.clr_breath) begin
            flow_total_nxt = 32'(c_r.flow);
            root_total_nxt = 28'(c_r.root);
          end else begin
            if (fsum > 33'sh07FFFFFFF) begin
              flow_total_nxt     = 32'sh7FFFFFFF;
              breath_invalid_nxt = 1'b1;
            end else if (fsum < -33'sh080000000) begin
              flow_total_nxt     = 32'sh80000000;
              breath_invalid_nxt = 1'b1;
            end else begin
              flow_total_nxt = fsum[31:0];
            end
            if (rsum[28]) begin
              root_total_nxt     = 28'hFFFFFFF;
              breath_invalid_nxt = 1'b1;
            end else begin
              root_total_nxt = rsum[27:0];
            end
          end
        end
        state_nxt = S_LEAK;
      end
      S_LEAK: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_v_r || !out_stall) begin
          out_nxt.leak_flow           = leak_r;
          out_nxt.coefficient         = coef_r;
          out_nxt.coefficient_valid   = coef_valid_r;
          out_nxt.balance_coefficient = balance_r;
          out_nxt.breath_finished     = fin_r;
          out_nxt.mean_leak           = mean_r;
          out_nxt.mean_leak_valid     = mean_ok_r;
          out_v_nxt                   = 1'b1;
          if (c_r.do_open) begin
            if (lsum[32]) begin
              leak_total_nxt        = '1;
              leak_mean_invalid_nxt = 1'b1;
            end else begin
              leak_total_nxt = lsum[31:0];
            end
            if (leak_samples_r != SMAX) leak_samples_nxt = leak_samples_r + COUNT_BITS'(1);
            else                        leak_mean_invalid_nxt = 1'b1;
            if (!coef_valid_r || !c_r.ok) leak_mean_invalid_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      out_v_r             <= 1'b0;
      flow_total_r        <= '0;
      root_total_r        <= '0;
      breath_invalid_r    <= 1'b0;
      coef_r              <= '0;
      coef_valid_r        <= 1'b0;
      balance_r           <= '0;
      leak_total_r        <= '0;
      leak_samples_r      <= '0;
      leak_mean_invalid_r <= 1'b0;
    end else begin
      state_r             <= state_nxt;
      out_v_r             <= out_v_nxt;
      flow_total_r        <= flow_total_nxt;
      root_total_r        <= root_total_nxt;
      breath_invalid_r    <= breath_invalid_nxt;
      coef_r              <= coef_nxt;
      coef_valid_r        <= coef_valid_nxt;
      balance_r           <= balance_nxt;
      leak_total_r        <= leak_total_nxt;
      leak_samples_r      <= leak_samples_nxt;
      leak_mean_invalid_r <= leak_mean_invalid_nxt;
    end
    c_r       <= c_nxt;
    fin_r     <= fin_nxt;
    mean_r    <= mean_nxt;
    mean_ok_r <= mean_ok_nxt;
    k_ok_r    <= k_ok_nxt;
    kneg_r    <= kneg_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    cnt_r     <= cnt_nxt;
    out_r     <= out_nxt;
  end

  // Leak product registered in APPLY, then saturated combinationally for OUT.
  always_ff @(posedge clk) begin
    if (state_r == S_APPLY) begin
      prod_r <= 24'(coef_r) * 24'(c_r.root);
    end
  end

  logic        leak_on;
  logic [17:0] leak_raw;
  assign leak_on  = coef_valid_r && (coef_r != 16'd0) && c_r.ok;
  assign leak_raw = prod_r[23:6];
  always_comb begin
    if (!leak_on)                            leak_r = '0;
    else if (leak_raw > 18'(cfg.leak_ceil))  leak_r = cfg.leak_ceil;
    else                                     leak_r = leak_raw[14:0];
  end

  a_fin_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.mean_leak_valid) |-> out_data.breath_finished)
    else $error("mean valid without finish");
  a_kdiv_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KDIV && cnt_r == 6'd1) |=> (state_r == S_MDIV))
    else $error("coefficient division did not hand over");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> cmd_stall)
    else $error("command taken while busy");

endmodule

// ===== hdl/breath_leak_estimator.sv =====
// Top level of the breath leak estimator: register file, front end, queue and back end.
//
//   port group   direction   word
//   in_*         input       ble_pkg::in_word_t   (mode, pressure, flow, readings_finite)
//   out_*        output      ble_pkg::out_word_t  (one result word per input word)
//   cfg_*        APB slave   four registers at byte addresses 0, 4, 8, 12
//
// The front end takes one word at a time and runs the 8-step pressure root on it.
// The back end takes one command at a time; when a breath finishes it runs the
// shared 38-step restoring divider once for K and once for the mean leak.
// Reset is synchronous; state, counts, sums and configuration return to reset values, datapath registers do not.
// Either side may stall at any time; a two-deep queue separates front and back.
module breath_leak_estimator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ble_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ble_pkg::out_word_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ble_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import ble_pkg::*;

  cfg_t cfg_r;
  logic cmd_v, cmd_s, q_v, q_s;
  cmd_t cmd_d, q_d;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_floor <= 16'd0;
      cfg_r.coef_ceil  <= 16'hFFFF;
      cfg_r.leak_ceil  <= 15'h7FFF;
      cfg_r.root_floor <= 28'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        ADDR_COEF_FLOOR: cfg_r.coef_floor <= cfg_pwdata[15:0];
        ADDR_COEF_CEIL:  cfg_r.coef_ceil  <= cfg_pwdata[15:0];
        ADDR_LEAK_CEIL:  cfg_r.leak_ceil  <= cfg_pwdata[14:0];
        ADDR_ROOT_FLOOR: cfg_r.root_floor <= cfg_pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      ADDR_COEF_FLOOR: cfg_prdata = {16'd0, cfg_r.coef_floor};
      ADDR_COEF_CEIL:  cfg_prdata = {16'd0, cfg_r.coef_ceil};
      ADDR_LEAK_CEIL:  cfg_prdata = {17'd0, cfg_r.leak_ceil};
      ADDR_ROOT_FLOOR: cfg_prdata = {4'd0, cfg_r.root_floor};
      default:         cfg_prdata = '0;
    endcase
  end

  ble_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid(cmd_v), .cmd_stall(cmd_s), .cmd_data(cmd_d)
  );

  ble_queue u_queue (
    .clk, .rst_n, .wr_valid(cmd_v), .wr_stall(cmd_s), .wr_data(cmd_d),
    .rd_valid(q_v), .rd_stall(q_s), .rd_data(q_d)
  );

  ble_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .cmd_valid(q_v), .cmd_stall(q_s), .cmd_data(q_d),
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== sim/ble_checker.sv =====
`timescale 1ns / 1ps
// Result checker: mirrors the estimator's arithmetic and compares every result word.
module ble_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ble_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ble_pkg::out_word_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [ble_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output int                 fail_count,
  output int                 pending
);
  import ble_pkg::*;

  logic [15:0] floor_q, ceil_q;
  logic [14:0] leak_ceil_q;
  logic [27:0] root_floor_q;

  longint      flow_sum;
  longint      root_sum;
  bit          breath_bad;
  logic [15:0] coef_q;
  bit          coef_ok;
  longint      balance_q;
  longint      leak_sum;
  longint      leak_count;
  bit          mean_bad;

  out_word_t   expected_words[$];

  function automatic longint isqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic void clear_breath();
    flow_sum = 0; root_sum = 0; breath_bad = 0;
    leak_sum = 0; leak_count = 0; mean_bad = 0;
  endfunction

  function automatic void clear_coef();
    coef_q = 0; coef_ok = 0; balance_q = 0;
  endfunction

  function automatic void close_breath(output logic [14:0] mean, output bit mean_ok);
    longint k;
    longint c;
    clear_coef();
    if (!breath_bad && root_sum != 0 && root_sum >= root_floor_q) begin
      k = (flow_sum * 64) / root_sum;
      balance_q = k > 8388607 ? 8388607 : (k < -8388608 ? -8388608 : k);
      c = k;
      if (c < longint'(floor_q)) c = floor_q;
      else if (c > longint'(ceil_q)) c = ceil_q;
      coef_q = c[15:0];
      coef_ok = 1;
    end
    if (!mean_bad && !breath_bad && leak_count != 0) begin
      mean = 15'(leak_sum / leak_count);
      mean_ok = 1;
    end else begin
      mean = 0;
      mean_ok = 0;
    end
  endfunction

  function automatic out_word_t predict_leak(in_word_t w);
    out_word_t r;
    longint p, f, v, leak;
    logic [14:0] mean;
    bit mean_ok, open;
    p = w.pressure; f = w.flow;
    mean = 0; mean_ok = 0; open = 0; leak = 0;
    r = '0;
    case (w.mode)
      MODE_OPEN: open = 1;
      MODE_FINRST: begin
        close_breath(mean, mean_ok); r.breath_finished = 1; clear_breath(); open = 1;
      end
      MODE_RST: begin
        clear_coef(); clear_breath(); open = 1;
      end
      MODE_FIN: begin
        close_breath(mean, mean_ok); r.breath_finished = 1;
      end
      MODE_IDLE: begin
        clear_breath(); clear_coef();
      end
      default: ;
    endcase
    if (open) begin
      if (!w.readings_finite || p <= 0) breath_bad = 1;
      else begin
        flow_sum += f;
        if (flow_sum > 64'sd2147483647) begin flow_sum = 2147483647; breath_bad = 1; end
        if (flow_sum < -64'sd2147483648) begin flow_sum = -2147483648; breath_bad = 1; end
        root_sum += isqrt(p);
        if (root_sum > 28'hFFFFFFF) begin root_sum = 28'hFFFFFFF; breath_bad = 1; end
      end
    end
    if (coef_ok && coef_q > 0 && w.readings_finite && p > 0) begin
      v = (longint'(coef_q) * isqrt(p)) >>> 6;
      leak = v > leak_ceil_q ? leak_ceil_q : v;
    end
    if (open) begin
      leak_sum += leak;
      if (leak_sum > 64'hFFFFFFFF) begin leak_sum = 64'hFFFFFFFF; mean_bad = 1; end
      if (leak_count < (1 << COUNT_BITS) - 1) leak_count++;
      else mean_bad = 1;
      if (!coef_ok || !w.readings_finite || p <= 0) mean_bad = 1;
    end
    r.leak_flow = leak[14:0];
    r.coefficient = coef_q;
    r.coefficient_valid = coef_ok;
    r.balance_coefficient = balance_q[23:0];
    r.mean_leak = mean;
    r.mean_leak_valid = mean_ok;
    return r;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      floor_q <= 0; ceil_q <= 16'hFFFF; leak_ceil_q <= 15'h7FFF; root_floor_q <= 1;
      clear_breath(); clear_coef();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr)
          ADDR_COEF_FLOOR: floor_q <= cfg_pwdata[15:0];
          ADDR_COEF_CEIL:  ceil_q <= cfg_pwdata[15:0];
          ADDR_LEAK_CEIL:  leak_ceil_q <= cfg_pwdata[14:0];
          ADDR_ROOT_FLOOR: root_floor_q <= cfg_pwdata[27:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_words.push_back(predict_leak(in_data));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_breath_leak_estimator.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus, register writes and the verdict.
module tb_breath_leak_estimator;
  import ble_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_word_t in_data;
  out_word_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending;
  int long_hold;

  breath_leak_estimator DUT (.*);

  ble_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("breath_leak_estimator verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1;
        long_hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 0;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic send_word(logic [2:0] m, logic [15:0] p, logic [15:0] f, logic fin,
                           bit gaps);
    int n;
    in_data <= '{mode: m, pressure: p, flow: f, readings_finite: fin};
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    if (gaps) begin
      n = gap_len();
      if (n > 0) begin
        in_valid <= 0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  task automatic reg_write(logic [CFG_ADDR_W-1:0] a, logic [31:0] d);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= a; cfg_pwdata <= d; cfg_penable <= 0;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic rand_sample(bit good);
    logic [15:0] p;
    p = good ? 16'($urandom_range(1, 32767)) : 16'($urandom);
    if ($urandom_range(0, 3) == 0) p = 16'($urandom_range(1, 400));
    send_word(MODE_OPEN, p, 16'($urandom_range(0, 800)) - 16'd100,
              good ? 1'b1 : 1'($urandom), 1);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_data = '0; long_hold = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed words: field extremes, every mode, invalid readings.
    send_word(MODE_RST, 16'h7FFF, 16'h7FFF, 1, 0);
    send_word(MODE_OPEN, 16'h0001, 16'h8000, 1, 0);
    send_word(MODE_OPEN, 16'h0100, 16'h0400, 1, 0);
    send_word(MODE_FINRST, 16'h7FFF, 16'h7FFF, 1, 0);
    send_word(MODE_OPEN, 16'h4000, 16'h1000, 1, 0);
    send_word(MODE_HELD, 16'h7FFF, 16'h0000, 1, 0);
    send_word(MODE_OPEN, 16'h0000, 16'h0100, 1, 0);
    send_word(MODE_OPEN, 16'h8000, 16'hFFFF, 1, 0);
    send_word(MODE_OPEN, 16'h2000, 16'h0100, 0, 0);
    send_word(MODE_FIN, 16'h0100, 16'h0100, 1, 0);
    send_word(MODE_FINRST, 16'h0400, 16'h0200, 1, 0);
    send_word(MODE_FIN, 16'h0400, 16'h0200, 1, 0);
    send_word(MODE_IDLE, 16'hFFFF, 16'hFFFF, 1, 0);
    send_word(3'd6, 16'h0100, 16'h0100, 1, 0);
    send_word(3'd7, 16'h0100, 16'h0100, 1, 0);
    send_word(MODE_FIN, 16'h0000, 16'h0000, 0, 0);
    drain();

    // Phases of random breaths under different register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin reg_write(ADDR_COEF_FLOOR, 32'd300); reg_write(ADDR_COEF_CEIL, 32'd100); end
        2: begin
          reg_write(ADDR_COEF_FLOOR, 32'd0); reg_write(ADDR_COEF_CEIL, 32'd20000);
          reg_write(ADDR_LEAK_CEIL, 32'd500); reg_write(ADDR_ROOT_FLOOR, 32'd2000);
        end
        3: begin reg_write(ADDR_ROOT_FLOOR, 32'hFFFFFFF); reg_write(ADDR_LEAK_CEIL, 32'd0); end
        4: begin
          reg_write(ADDR_COEF_FLOOR, 32'hFFFF); reg_write(ADDR_COEF_CEIL, 32'hFFFF);
          reg_write(ADDR_ROOT_FLOOR, 32'd0); reg_write(ADDR_LEAK_CEIL, 32'h7FFF);
        end
        5: begin
          reg_write(ADDR_COEF_FLOOR, 32'd0); reg_write(ADDR_COEF_CEIL, 32'hFFFF);
          reg_write(ADDR_ROOT_FLOOR, 32'd1);
        end
        default: ;
      endcase
      if (ph == 2) long_hold = 400;
      for (int b = 0; b < 8; b++) begin
        int len;
        len = $urandom_range(1, 20);
        send_word($urandom_range(0, 4) == 0 ? MODE_RST : MODE_FINRST,
                  16'($urandom_range(1, 32767)), 16'($urandom_range(0, 600)), 1, 1);
        for (int s = 0; s < len; s++) begin
          case ($urandom_range(0, 19))
            0: send_word(MODE_HELD, 16'($urandom), 16'($urandom), 1'($urandom), 1);
            1: send_word(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                         1'($urandom), 1);
            2: rand_sample(0);
            default: rand_sample(1);
          endcase
        end
        if ($urandom_range(0, 5) == 0) send_word(MODE_FIN, 16'($urandom), 16'($urandom),
                                                 1'($urandom), 1);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("breath_leak_estimator verification clean");
    end else begin
      $display("breath_leak_estimator verification failed");
    end
    $finish;
  end
endmodule
